// ===== hdl/dbu_pkg.sv =====
// ----------------------------------------------------------------------------
// dbu_pkg
// Shared constants, codes and helpers for the dissemination barrier unit.
// ----------------------------------------------------------------------------
package dbu_pkg;

  localparam int DEF_MAX_THREADS = 64;
  localparam int DEF_MAX_ROUNDS  = 6;

  // result status codes
  localparam logic [1:0] ST_WAIT = 2'd0;
  localparam logic [1:0] ST_ADV  = 2'd1;
  localparam logic [1:0] ST_REL  = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  // action codes
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_POLL   = 1'b1;

  // ceil(log2(p)) for p >= 1: one past the top set bit of p - 1
  function automatic int unsigned ceil_log2(input logic [31:0] p);
    logic [31:0] pm1;
    int unsigned res;
    pm1 = p - 32'd1;
    res = 0;
    for (int i = 0; i < 32; i++) begin
      if (pm1[i]) begin
        res = i + 1;
      end
    end
    return res;
  endfunction

endpackage

// ===== hdl/dbu_ram.sv =====
// ----------------------------------------------------------------------------
// dbu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/dbu_sweep.sv =====
// ----------------------------------------------------------------------------
// dbu_sweep
// Clearing pass: walks every address once after reset or a restart.
// ----------------------------------------------------------------------------
module dbu_sweep #(
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  output logic [$clog2(DEPTH)-1:0] addr
);

  localparam int AW = $clog2(DEPTH);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      addr <= '0;
    end else if (busy) begin
      if (addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      addr <= addr + AW'(1);
    end
  end

endmodule

// ===== hdl/dissemination_barrier_unit.sv =====
// ----------------------------------------------------------------------------
// dissemination_barrier_unit
// Hardware dissemination barrier: arrive and poll actions of many threads.
// ----------------------------------------------------------------------------
// One action transaction in, one result transaction out. An arrive reads the
// per-thread state RAM, then updates; a poll reads the thread state, then
// its own flag from the flag RAM, then updates. An error is reported after
// the thread state read. Both RAMs have a registered read.
// After reset and after every num_threads write a clearing pass walks the
// MAX_THREADS*MAX_ROUNDS*2 flag addresses (768 by default), zeroing every
// flag and restoring every thread to parity 0, sense 1, round 0, inactive;
// act_stall stays high during the pass. A finished result sits in an output
// register, so the next action can start while it waits to be taken.
// ----------------------------------------------------------------------------
module dissemination_barrier_unit #(
  parameter int MAX_THREADS = dbu_pkg::DEF_MAX_THREADS,
  parameter int MAX_ROUNDS  = dbu_pkg::DEF_MAX_ROUNDS
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration: num_threads
  input  logic                             cfg_wr_en,
  input  logic [$clog2(MAX_THREADS+1)-1:0] cfg_wr_data,
  // action channel
  input  logic                             act_valid,
  output logic                             act_stall,
  input  logic [$clog2(MAX_THREADS)-1:0]   thread,
  input  logic                             command,
  // result channel
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [1:0]                       status,
  output logic [$clog2(MAX_ROUNDS+1)-1:0]  round,
  output logic                             sense
);

  import dbu_pkg::*;

  localparam int TW         = $clog2(MAX_THREADS);
  localparam int PW         = $clog2(MAX_THREADS + 1);
  localparam int RW         = $clog2(MAX_ROUNDS + 1);
  localparam int FLAG_DEPTH = MAX_THREADS * MAX_ROUNDS * 2;
  localparam int FAW        = $clog2(FLAG_DEPTH);
  localparam int SW         = RW + 3;   // {active, round, sense, parity}

  localparam logic [SW-1:0] THR_RESET = {1'b0, {RW{1'b0}}, 1'b1, 1'b0};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TST  = 2'd1;   // thread state valid
  localparam logic [1:0] S_FLG  = 2'd2;   // own flag valid

  // flag RAM address of (thread, round, parity)
  function automatic logic [FAW-1:0] flag_addr(input logic [TW-1:0] t,
                                               input logic [RW-1:0] r,
                                               input logic          p);
    return ((FAW'(t) * FAW'(MAX_ROUNDS) + FAW'(r)) << 1) | FAW'(p);
  endfunction

  // config and control registers
  logic [PW-1:0] num_thr;
  logic [RW-1:0] round_count;
  logic [1:0]    state, state_next;
  logic [TW-1:0] t_q;
  logic          cmd_q;

  // clearing pass
  logic           sweep_busy;
  logic [FAW-1:0] sweep_addr;

  // RAM ports
  logic           thr_wr_en, flag_wr_en, flag_rd_en;
  logic [TW-1:0]  thr_wr_addr;
  logic [SW-1:0]  thr_wr_data, thr_rd_data;
  logic [FAW-1:0] flag_wr_addr, flag_rd_addr;
  logic           flag_wr_data, flag_rd_data;

  // per-action update
  logic           act_acc, out_free, fin;
  logic           op_thr_we, op_flag_we;
  logic [SW-1:0]  op_thr_wd;
  logic [FAW-1:0] op_flag_addr;
  logic           op_flag_wd;
  logic [1:0]     res_status;
  logic [RW-1:0]  res_round;
  logic           res_sense;

  // current thread state fields
  logic          cur_par, cur_sen, cur_act;
  logic [RW-1:0] cur_rnd;
  logic          in_mem, t_ok;
  logic [RW-1:0] r1;
  logic [TW:0]   tp1, hop, psum;

  // clamped register value and its round count
  logic [PW-1:0] cfg_p;
  int unsigned   cfg_rc;

  always_comb begin
    cfg_p = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      cfg_p = PW'(1);
    end else if (cfg_wr_data > PW'(MAX_THREADS)) begin
      cfg_p = PW'(MAX_THREADS);
    end
    cfg_rc = ceil_log2(32'(cfg_p));
    if (cfg_rc > MAX_ROUNDS) begin
      cfg_rc = MAX_ROUNDS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_thr     <= PW'(1);
      round_count <= '0;
    end else if (cfg_wr_en) begin
      num_thr     <= cfg_p;
      round_count <= RW'(cfg_rc);
    end
  end

  dbu_sweep #(
    .DEPTH (FLAG_DEPTH)
  ) u_sweep (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_wr_en),
    .busy  (sweep_busy),
    .addr  (sweep_addr)
  );

  // handshake
  assign act_stall = rst || sweep_busy || (state != S_IDLE);
  assign act_acc   = act_valid && !act_stall;
  assign out_free  = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (act_acc) begin
      t_q   <= thread;
      cmd_q <= command;
    end
  end

  // unpack thread state
  assign cur_par = thr_rd_data[0];
  assign cur_sen = thr_rd_data[1];
  assign cur_rnd = thr_rd_data[RW+1:2];
  assign cur_act = thr_rd_data[RW+2];

  assign in_mem = {1'b0, t_q} < (TW+1)'(MAX_THREADS);
  assign t_ok   = in_mem && ({1'b0, t_q} < (TW+1)'(num_thr));
  assign tp1    = {1'b0, t_q} + (TW+1)'(1);
  assign r1     = cur_rnd + RW'(1);
  // 2^r1 < P whenever the round is not the last, so one subtraction of P wraps
  assign hop    = (TW+1)'(1) << r1;
  assign psum   = {1'b0, t_q} + hop;

  always_comb begin
    logic [TW:0] partner;
    partner      = '0;
    state_next   = state;
    fin          = 1'b0;
    op_thr_we    = 1'b0;
    op_thr_wd    = thr_rd_data;
    op_flag_we   = 1'b0;
    op_flag_addr = '0;
    op_flag_wd   = cur_sen;
    flag_rd_en   = 1'b0;
    flag_rd_addr = flag_addr(t_q, cur_rnd, cur_par);
    res_status   = ST_ERR;
    res_round    = '0;
    res_sense    = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (act_acc) begin
          state_next = S_TST;
        end
      end
      S_TST: begin
        if (!t_ok || (cmd_q == CMD_ARRIVE && cur_act) ||
            (cmd_q == CMD_POLL && !cur_act)) begin
          fin        = 1'b1;
          res_status = ST_ERR;
          res_round  = in_mem ? cur_rnd : '0;
          res_sense  = in_mem ? cur_sen : 1'b0;
        end else if (cmd_q == CMD_ARRIVE) begin
          fin       = 1'b1;
          op_thr_we = 1'b1;
          res_round = '0;
          if (round_count == '0) begin
            // single thread: released on arrival
            op_thr_wd  = {1'b0, RW'(0), cur_sen ^ cur_par, ~cur_par};
            res_status = ST_REL;
            res_sense  = cur_sen ^ cur_par;
          end else begin
            op_thr_wd    = {1'b1, RW'(0), cur_sen, cur_par};
            partner      = (tp1 == (TW+1)'(num_thr)) ? '0 : tp1;
            op_flag_we   = 1'b1;
            op_flag_addr = flag_addr(partner[TW-1:0], RW'(0), cur_par);
            res_status   = ST_WAIT;
            res_sense    = cur_sen;
          end
        end else begin
          flag_rd_en = 1'b1;
          state_next = S_FLG;
        end
      end
      S_FLG: begin
        fin = 1'b1;
        if (cur_rnd >= RW'(MAX_ROUNDS) || flag_rd_data != cur_sen) begin
          res_status = ST_WAIT;
          res_round  = cur_rnd;
          res_sense  = cur_sen;
        end else begin
          op_thr_we = 1'b1;
          res_round = r1;
          if (r1 >= round_count) begin
            op_thr_wd  = {1'b0, r1, cur_sen ^ cur_par, ~cur_par};
            res_status = ST_REL;
            res_sense  = cur_sen ^ cur_par;
          end else begin
            op_thr_wd    = {1'b1, r1, cur_sen, cur_par};
            partner      = (psum >= (TW+1)'(num_thr)) ? psum - (TW+1)'(num_thr) : psum;
            op_flag_we   = 1'b1;
            op_flag_addr = flag_addr(partner[TW-1:0], r1, cur_par);
            res_status   = ST_ADV;
            res_sense    = cur_sen;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // a finished action waits here until the output register is free
    if (fin) begin
      state_next = out_free ? S_IDLE : state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin && out_free) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && out_free) begin
      status <= res_status;
      round  <= res_round;
      sense  <= res_sense;
    end
  end

  // RAM write muxes: clearing pass owns both RAMs while it runs
  always_comb begin
    if (sweep_busy) begin
      thr_wr_en    = sweep_addr < FAW'(MAX_THREADS);
      thr_wr_addr  = sweep_addr[TW-1:0];
      thr_wr_data  = THR_RESET;
      flag_wr_en   = 1'b1;
      flag_wr_addr = sweep_addr;
      flag_wr_data = 1'b0;
    end else begin
      thr_wr_en    = op_thr_we && fin && out_free;
      thr_wr_addr  = t_q;
      thr_wr_data  = op_thr_wd;
      flag_wr_en   = op_flag_we && fin && out_free;
      flag_wr_addr = op_flag_addr;
      flag_wr_data = op_flag_wd;
    end
  end

  dbu_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_THREADS)
  ) u_thr_ram (
    .clk     (clk),
    .wr_en   (thr_wr_en),
    .wr_addr (thr_wr_addr),
    .wr_data (thr_wr_data),
    .rd_en   (act_acc),
    .rd_addr (thread),
    .rd_data (thr_rd_data)
  );

  dbu_ram #(
    .WIDTH (1),
    .DEPTH (FLAG_DEPTH)
  ) u_flag_ram (
    .clk     (clk),
    .wr_en   (flag_wr_en),
    .wr_addr (flag_wr_addr),
    .wr_data (flag_wr_data),
    .rd_en   (flag_rd_en),
    .rd_addr (flag_rd_addr),
    .rd_data (flag_rd_data)
  );

endmodule

// ===== tb/sv/tb_dissemination_barrier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dissemination_barrier_unit
// Self-checking bench for the dissemination barrier unit. A table of directed
// actions runs first, then barrier episodes with random thread order over a
// series of thread counts. Every result is checked in order, against its row's
// typed outcome or else an in-bench model of flags, rounds, parities, senses.
// ----------------------------------------------------------------------------
module tb_dissemination_barrier_unit;
  import dbu_pkg::*;

  // one result transaction
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] round;
    logic       sense;
  } outcome_t;

  // one row of the directed table: either a num_threads write or an action;
  // typed rows carry their expected outcome, the others use the model
  typedef struct packed {
    bit         is_cfg;
    logic [6:0] cfg_val;
    logic [5:0] thd;
    logic       cmd;
    bit         typed;
    outcome_t   want;
  } dir_row_t;

  localparam int NUM_DIR = 29;
  localparam int PHASE_ITEMS = 71;

  // DUT inputs, all known from time zero
  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       cfg_wr_en   = 1'b0;
  logic [6:0] cfg_wr_data = 7'd0;
  logic       act_valid   = 1'b0;
  logic [5:0] act_thread  = 6'd0;
  logic       act_command = CMD_ARRIVE;
  logic       res_stall   = 1'b0;
  // DUT outputs
  logic       act_stall;
  logic       res_valid;
  logic [1:0] res_status;
  logic [2:0] res_round;
  logic       res_sense;

  // barrier model state
  bit         flag_mem   [0:63][0:5][0:1];
  bit         parity_bit [0:63];
  bit         sense_bit  [0:63];
  bit         active_bit [0:63];
  logic [2:0] round_mem  [0:63];
  int         num_thr;
  int         round_total;

  outcome_t   pending_results[$];
  int         fault_count = 0;
  bit         idle_on = 1'b1;   // random idling on both sides when set
  int         stall_left = 0;

  // thread count settings for the random episodes; the last one runs with
  // no idling at all
  int phase_cfg[13] = '{2, 5, 4, 3, 64, 8, 0, 7, 6, 127, 1, 3, 2};

  // directed table
  dir_row_t dir_rows [0:NUM_DIR-1] = '{
    // after reset: one thread, no rounds, so arrive releases at once
    '{1'b0, 7'd0,   6'd0,  CMD_ARRIVE, 1'b1, '{ST_REL,  3'd0, 1'b1}},
    '{1'b0, 7'd0,   6'd0,  CMD_ARRIVE, 1'b1, '{ST_REL,  3'd0, 1'b0}},
    '{1'b0, 7'd0,   6'd0,  CMD_POLL,   1'b1, '{ST_ERR,  3'd0, 1'b0}},
    '{1'b0, 7'd0,   6'd63, CMD_ARRIVE, 1'b1, '{ST_ERR,  3'd0, 1'b1}},
    // two threads, one round
    '{1'b1, 7'd2,   6'd0,  CMD_ARRIVE, 1'b0, '{ST_WAIT, 3'd0, 1'b0}},
    '{1'b0, 7'd0,   6'd0,  CMD_ARRIVE, 1'b1, '{ST_WAIT, 3'd0, 1'b1}},
    '{1'b0, 7'd0,   6'd0,  CMD_ARRIVE, 1'b1, '{ST_ERR,  3'd0, 1'b1}},
    '{1'b0, 7'd0,   6'd0,  CMD_POLL,   1'b1, '{ST_WAIT, 3'd0, 1'b1}},
    '{1'b0, 7'd0,   6'd1,  CMD_ARRIVE, 1'b1, '{ST_WAIT, 3'd0, 1'b1}},
    '{1'b0, 7'd0,   6'd0,  CMD_POLL,   1'b1, '{ST_REL,  3'd1, 1'b1}},
    '{1'b0, 7'd0,   6'd1,  CMD_POLL,   1'b1, '{ST_REL,  3'd1, 1'b1}},
    '{1'b0, 7'd0,   6'd1,  CMD_POLL,   1'b1, '{ST_ERR,  3'd1, 1'b1}},
    // zero threads acts as one
    '{1'b1, 7'd0,   6'd0,  CMD_ARRIVE, 1'b0, '{ST_WAIT, 3'd0, 1'b0}},
    '{1'b0, 7'd0,   6'd0,  CMD_ARRIVE, 1'b1, '{ST_REL,  3'd0, 1'b1}},
    '{1'b0, 7'd0,   6'd1,  CMD_ARRIVE, 1'b1, '{ST_ERR,  3'd0, 1'b1}},
    // oversize count clamps to 64 threads, six rounds
    '{1'b1, 7'd127, 6'd0,  CMD_ARRIVE, 1'b0, '{ST_WAIT, 3'd0, 1'b0}},
    '{1'b0, 7'd0,   6'd63, CMD_ARRIVE, 1'b1, '{ST_WAIT, 3'd0, 1'b1}},
    '{1'b0, 7'd0,   6'd63, CMD_POLL,   1'b1, '{ST_WAIT, 3'd0, 1'b1}},
    '{1'b0, 7'd0,   6'd0,  CMD_ARRIVE, 1'b1, '{ST_WAIT, 3'd0, 1'b1}},
    '{1'b0, 7'd0,   6'd0,  CMD_POLL,   1'b1, '{ST_ADV,  3'd1, 1'b1}},
    '{1'b0, 7'd0,   6'd0,  CMD_POLL,   1'b1, '{ST_WAIT, 3'd1, 1'b1}},
    '{1'b0, 7'd0,   6'd5,  CMD_POLL,   1'b1, '{ST_ERR,  3'd0, 1'b1}},
    // three threads: wrap-around partners, model-checked
    '{1'b1, 7'd3,   6'd0,  CMD_ARRIVE, 1'b0, '{ST_WAIT, 3'd0, 1'b0}},
    '{1'b0, 7'd0,   6'd0,  CMD_ARRIVE, 1'b0, '{ST_WAIT, 3'd0, 1'b0}},
    '{1'b0, 7'd0,   6'd1,  CMD_ARRIVE, 1'b0, '{ST_WAIT, 3'd0, 1'b0}},
    '{1'b0, 7'd0,   6'd2,  CMD_ARRIVE, 1'b0, '{ST_WAIT, 3'd0, 1'b0}},
    '{1'b0, 7'd0,   6'd2,  CMD_POLL,   1'b0, '{ST_WAIT, 3'd0, 1'b0}},
    '{1'b0, 7'd0,   6'd0,  CMD_POLL,   1'b0, '{ST_WAIT, 3'd0, 1'b0}},
    '{1'b0, 7'd0,   6'd3,  CMD_ARRIVE, 1'b1, '{ST_ERR,  3'd0, 1'b1}}
  };

  dissemination_barrier_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .act_valid  (act_valid),
    .act_stall  (act_stall),
    .thread     (act_thread),
    .command    (act_command),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .status     (res_status),
    .round      (res_round),
    .sense      (res_sense)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Load a thread count: clamp to 1..64, derive the round count (capped at
  // six) and wipe every flag and per-thread field, as the register write does.
  function automatic void set_thread_count(input logic [6:0] v);
    int p;
    p = int'(v);
    if (p < 1) p = 1;
    if (p > 64) p = 64;
    num_thr = p;
    round_total = 0;
    while ((1 << round_total) < p) round_total++;
    if (round_total > 6) round_total = 6;
    for (int t = 0; t < 64; t++) begin
      parity_bit[t] = 1'b0;
      sense_bit[t]  = 1'b1;
      active_bit[t] = 1'b0;
      round_mem[t]  = 3'd0;
      for (int r = 0; r < 6; r++) begin
        flag_mem[t][r][0] = 1'b0;
        flag_mem[t][r][1] = 1'b0;
      end
    end
  endfunction

  // Apply one action to the model and return the outcome it reports.
  function automatic outcome_t step_barrier(input int t, input logic cmd);
    outcome_t res;
    int r;
    int hop;
    bit par;
    bit sns;
    if (t >= num_thr) begin
      res.status = ST_ERR;
    end else if (cmd == CMD_ARRIVE) begin
      if (active_bit[t]) begin
        res.status = ST_ERR;
      end else begin
        round_mem[t] = 3'd0;
        if (round_total == 0) begin
          // no rounds to run: released on arrival
          if (parity_bit[t]) sense_bit[t] = ~sense_bit[t];
          parity_bit[t] = ~parity_bit[t];
          res.status = ST_REL;
        end else begin
          active_bit[t] = 1'b1;
          flag_mem[(t + 1) % num_thr][0][parity_bit[t]] = sense_bit[t];
          res.status = ST_WAIT;
        end
      end
    end else begin
      if (!active_bit[t]) begin
        res.status = ST_ERR;
      end else begin
        r   = int'(round_mem[t]);
        par = parity_bit[t];
        sns = sense_bit[t];
        if (r >= 6 || flag_mem[t][r][par] != sns) begin
          res.status = ST_WAIT;
        end else begin
          r++;
          round_mem[t] = r[2:0];
          if (r >= round_total) begin
            if (parity_bit[t]) sense_bit[t] = ~sense_bit[t];
            parity_bit[t] = ~parity_bit[t];
            active_bit[t] = 1'b0;
            res.status = ST_REL;
          end else begin
            // signal the partner for the new round
            hop = (1 << r) % num_thr;
            flag_mem[(t + hop) % num_thr][r][par] = sns;
            res.status = ST_ADV;
          end
        end
      end
    end
    res.round = round_mem[t];
    res.sense = sense_bit[t];
    return res;
  endfunction

  // Drop valid and hold off until every outstanding result has been taken.
  task automatic drain_results();
    @(negedge clk);
    act_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write num_threads with the block idle; the clearing pass that follows is
  // covered by the stall on the action channel.
  task automatic write_thread_count(input logic [6:0] v);
    drain_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    set_thread_count(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Present one action, wait for the handshake, then record the outcome:
  // the typed one where given, otherwise the model's. A random gap may follow.
  task automatic issue_action(input logic [5:0] thd, input logic cmd,
                              input bit typed, input outcome_t want);
    outcome_t predicted;
    @(negedge clk);
    act_valid   <= 1'b1;
    act_thread  <= thd;
    act_command <= cmd;
    @(posedge clk);
    while (act_stall) @(posedge clk);
    predicted = step_barrier(int'(thd), cmd);
    pending_results.push_back(typed ? want : predicted);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      act_valid <= 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk);
    end
  endtask

  // Result side back-pressure: random stall bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      res_stall <= 1'b1;
      stall_left <= $urandom_range(1, 13) - 1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Result checker: in-order compare against the oldest expectation.
  always @(posedge clk) begin
    outcome_t exp_res;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status %0d round %0d sense %0d",
               res_status, res_round, res_sense);
        fault_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (res_status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, res_status);
          fault_count++;
        end
        if (res_round !== exp_res.round) begin
          $error("round: expected %0d, got %0d", exp_res.round, res_round);
          fault_count++;
        end
        if (res_sense !== exp_res.sense) begin
          $error("sense: expected %0d, got %0d", exp_res.sense, res_sense);
          fault_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random episodes, drain, verdict.
  initial begin
    dir_row_t row;
    logic [5:0] thd;
    logic cmd;
    set_thread_count(7'd1);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table; the first action also waits out the clearing pass
    for (int i = 0; i < NUM_DIR; i++) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        write_thread_count(row.cfg_val);
      end else begin
        issue_action(row.thd, row.cmd, row.typed, row.want);
      end
    end

    // Random episodes. Most actions are what a well-behaved thread does:
    // arrive when out of the barrier, poll while in it. Picking threads at
    // random gives every interleaving of rounds and lets released threads
    // race ahead into the next episode on the other parity. One action in ten
    // is noise over the whole thread field and both commands.
    foreach (phase_cfg[ph]) begin
      idle_on = (ph != $size(phase_cfg) - 1) && ($urandom_range(0, 3) != 0);
      write_thread_count(phase_cfg[ph][6:0]);
      repeat (PHASE_ITEMS) begin
        if (idle_on && $urandom_range(0, 59) == 0) drain_results();
        if ($urandom_range(0, 9) == 0) begin
          thd = 6'($urandom_range(0, 63));
          cmd = 1'($urandom_range(0, 1));
        end else begin
          thd = 6'($urandom_range(0, num_thr - 1));
          cmd = active_bit[thd] ? CMD_POLL : CMD_ARRIVE;
        end
        issue_action(thd, cmd, 1'b0, '0);
      end
    end

    drain_results();
    // wait on to catch any stray result
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard: well beyond the slowest legal run, clearing passes included.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
